// ----- src/di_pkg.sv -----
`default_nettype none

package di_pkg;

    localparam int PRICE_BITS  = 32;
    localparam int MAX_PERIOD  = 1024;
    localparam int PERIOD_BITS = 11;
    localparam int FRAC_BITS   = 16;
    localparam int TERM_BITS   = PRICE_BITS + FRAC_BITS;
    localparam int SUM_BITS    = 58;
    localparam int DI_BITS     = 23;
    localparam int SCALE_SHIFT = 7;
    localparam int SCALED_BITS = SUM_BITS + SCALE_SHIFT;
    localparam int ITER_BITS   = 6;

    localparam logic [ITER_BITS-1:0]   SUM_ITERS  = ITER_BITS'(SUM_BITS);
    localparam logic [ITER_BITS-1:0]   DI_ITERS   = ITER_BITS'(DI_BITS);
    localparam logic [DI_BITS-1:0]     DI_SCALE   = DI_BITS'(6553600);
    localparam logic [PERIOD_BITS-1:0] PERIOD_RST = PERIOD_BITS'(14);
    localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = PERIOD_BITS'(MAX_PERIOD);
    localparam logic [PERIOD_BITS-1:0] COUNT_MAX  = {PERIOD_BITS{1'b1}};
    localparam logic [SUM_BITS-1:0]    SUM_MAX    = {SUM_BITS{1'b1}};

    localparam logic [1:0] SEL_RANGE = 2'd0;
    localparam logic [1:0] SEL_UP    = 2'd1;
    localparam logic [1:0] SEL_DOWN  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TERMS,
        ST_DIV,
        ST_DIV_WAIT,
        ST_SUB,
        ST_ACC,
        ST_DI_PREP,
        ST_DI_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [ITER_BITS-1:0] iters;
    } t_div_req;

endpackage

`default_nettype wire

// ----- src/di_divider.sv -----
`default_nettype none

// restoring divider, one quotient bit per cycle
module di_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire di_pkg::t_div_req              i_req,
    input  wire logic [di_pkg::SUM_BITS-1:0]   i_rem_init,  // must be below divisor
    input  wire logic [di_pkg::SUM_BITS-1:0]   i_bits,      // shifted in msb first
    input  wire logic [di_pkg::SUM_BITS-1:0]   i_divisor,
    output logic                               o_done,
    output logic      [di_pkg::SUM_BITS-1:0]   o_quot
);
    import di_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [ITER_BITS-1:0] r_cnt;
    logic [SUM_BITS-1:0]  r_rem;
    logic [SUM_BITS-1:0]  r_bits;
    logic [SUM_BITS-1:0]  r_div;
    logic [SUM_BITS-1:0]  r_quot;

    logic [SUM_BITS:0]    trial;
    logic [SUM_BITS:0]    diff;
    logic                 fits;
    logic [SUM_BITS-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_bits[SUM_BITS-1]};
        diff  = trial - {1'b0, r_div};
        fits  = trial >= {1'b0, r_div};
        n_rem = fits ? diff[SUM_BITS-1:0] : trial[SUM_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ITER_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_rem_init;
            r_bits <= i_bits;
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_bits <= {r_bits[SUM_BITS-2:0], 1'b0};
            r_quot <= {r_quot[SUM_BITS-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ----- src/directional_indicator.sv -----
`default_nettype none

// channel   dir  handshake                  payload
// s stream  in   i_s_tvalid / o_s_tready    tdata: high, low, close; tuser: series start
// m stream  out  o_m_tvalid / i_m_tready    tdata: plus di, minus di
// cfg       in   i_cfg_valid / o_cfg_ready  smoothing period
//
// one bar at a time; a shared restoring divider does one quotient bit per cycle.
// warm-up bars only accumulate, plus up to two 23-bit di divides when di is produced;
// smoothed bars add three 58-bit divides by the period. the next bar is taken while
// the last result waits on m.
// reset is synchronous: sums and previous bar clear, period returns to 14.
module directional_indicator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [95:0] i_s_tdata,   // bar_high, bar_low, bar_close
    input  wire logic [0:0]  i_s_tuser,   // series_start
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [47:0] o_m_tdata,   // plus_di, down_di, zero pad
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [di_pkg::PERIOD_BITS-1:0] i_cfg_data
);
    import di_pkg::*;

    t_state r_state, n_state;

    logic [PERIOD_BITS-1:0] r_cfg_period;
    logic [PRICE_BITS-1:0]  r_high, r_low, r_close;
    logic [PRICE_BITS-1:0]  r_prev_high, r_prev_low, r_prev_close;
    logic [PERIOD_BITS-1:0] r_bars;
    logic [SUM_BITS-1:0]    r_range_sum, r_up_sum, r_down_sum;
    logic [TERM_BITS-1:0]   r_range_term, r_up_term, r_down_term;
    logic                   r_warm, r_emit;
    logic [1:0]             r_sel;
    logic [DI_BITS-1:0]     r_plus, r_minus;
    logic                   r_out_valid;
    logic [DI_BITS-1:0]     r_out_plus, r_out_minus;

    logic [PERIOD_BITS-1:0] period;
    logic                   s_xfer;
    logic                   out_free;
    logic                   has_terms, warm_bar, emit_bar;

    // bar terms
    logic [PRICE_BITS-1:0]  d_hl, d_hc, d_lc, tr_a, true_range;
    logic [PRICE_BITS-1:0]  up_mv, down_mv, plus_dm, minus_dm;

    // shared sum datapath
    logic [SUM_BITS-1:0]    cur_sum;
    logic [TERM_BITS-1:0]   cur_term;
    logic [SUM_BITS:0]      acc_sum;
    logic [SUM_BITS-1:0]    acc_sat;
    logic [SUM_BITS-1:0]    sub_sum;

    // di setup
    logic [SUM_BITS-1:0]    di_num;
    logic [SCALED_BITS-1:0] di_ext, di_scaled;
    logic                   di_zero, di_full;
    logic [DI_BITS-1:0]     di_quick;

    // divider
    t_div_req               div_req;
    logic [SUM_BITS-1:0]    div_rem_init, div_bits, div_divisor;
    logic                   div_done;
    logic [SUM_BITS-1:0]    div_quot;

    assign period = (r_cfg_period == '0)        ? PERIOD_BITS'(1) :
                    (r_cfg_period > PERIOD_MAX) ? PERIOD_MAX : r_cfg_period;

    // bar index of the bar in ST_TERMS
    assign has_terms = r_bars != '0;
    assign warm_bar  = r_bars < period;
    assign emit_bar  = r_bars >= period - 1'b1;

    assign s_xfer      = i_s_tvalid & o_s_tready;
    assign out_free    = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {2'b00, r_out_minus, r_out_plus};

    always_comb begin
        d_hl       = (r_high >= r_low) ? r_high - r_low : r_low - r_high;
        d_hc       = (r_high >= r_prev_close) ? r_high - r_prev_close : r_prev_close - r_high;
        d_lc       = (r_low >= r_prev_close) ? r_low - r_prev_close : r_prev_close - r_low;
        tr_a       = (d_hc > d_hl) ? d_hc : d_hl;
        true_range = (d_lc > tr_a) ? d_lc : tr_a;
        up_mv      = (r_high > r_prev_high) ? r_high - r_prev_high : '0;
        down_mv    = (r_prev_low > r_low) ? r_prev_low - r_low : '0;
        plus_dm    = (up_mv > down_mv) ? up_mv : '0;
        minus_dm   = (down_mv > up_mv) ? down_mv : '0;
    end

    always_comb begin
        case (r_sel)
            SEL_RANGE: begin
                cur_sum  = r_range_sum;
                cur_term = r_range_term;
            end
            SEL_UP: begin
                cur_sum  = r_up_sum;
                cur_term = r_up_term;
            end
            default: begin
                cur_sum  = r_down_sum;
                cur_term = r_down_term;
            end
        endcase
        acc_sum = {1'b0, cur_sum} + {{(SUM_BITS + 1 - TERM_BITS){1'b0}}, cur_term};
        acc_sat = acc_sum[SUM_BITS] ? SUM_MAX : acc_sum[SUM_BITS-1:0];
        sub_sum = cur_sum - div_quot;
    end

    // 100 * 2^16 * num / den: num*100 feeds the divider, the 2^16 comes from the shift-in bits
    always_comb begin
        di_num    = r_sel[0] ? r_down_sum : r_up_sum;
        di_ext    = {{SCALE_SHIFT{1'b0}}, di_num};
        di_scaled = (di_ext << 6) + (di_ext << 5) + (di_ext << 2);
        di_zero   = (di_num == '0) || (r_range_sum == '0);
        di_full   = di_num >= r_range_sum;
        di_quick  = di_zero ? '0 : DI_SCALE;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_xfer) n_state = ST_TERMS;
            end
            ST_TERMS: begin
                if (!has_terms) n_state = emit_bar ? ST_DI_PREP : ST_IDLE;
                else n_state = warm_bar ? ST_ACC : ST_DIV;
            end
            ST_DIV: begin
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) n_state = ST_SUB;
            end
            ST_SUB: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (r_sel == SEL_DOWN) n_state = r_emit ? ST_DI_PREP : ST_IDLE;
                else n_state = r_warm ? ST_ACC : ST_DIV;
            end
            ST_DI_PREP: begin
                if (!(di_zero || di_full)) n_state = ST_DI_WAIT;
                else if (r_sel[0]) n_state = ST_OUT;
            end
            ST_DI_WAIT: begin
                if (div_done) n_state = r_sel[0] ? ST_OUT : ST_DI_PREP;
            end
            ST_OUT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_tready    = 1'b0;
        div_req.start = 1'b0;
        div_req.iters = SUM_ITERS;
        div_rem_init  = '0;
        div_bits      = cur_sum;
        div_divisor   = {{(SUM_BITS - PERIOD_BITS){1'b0}}, period};
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
            end
            ST_DIV: begin
                div_req.start = 1'b1;
            end
            ST_DI_PREP: begin
                div_req.start = !(di_zero || di_full);
                div_req.iters = DI_ITERS;
                div_rem_init  = di_scaled[SCALED_BITS-1:SCALE_SHIFT];
                div_bits      = {di_scaled[SCALE_SHIFT-1:0], {(SUM_BITS - SCALE_SHIFT){1'b0}}};
                div_divisor   = r_range_sum;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    di_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_rem_init (div_rem_init),
        .i_bits     (div_bits),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_period <= PERIOD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg_period <= i_cfg_data;
        end
    end

    // model state and sum updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_high  <= '0;
            r_prev_low   <= '0;
            r_prev_close <= '0;
            r_bars       <= '0;
            r_range_sum  <= '0;
            r_up_sum     <= '0;
            r_down_sum   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (s_xfer && i_s_tuser[0]) begin
                        r_bars      <= '0;
                        r_range_sum <= '0;
                        r_up_sum    <= '0;
                        r_down_sum  <= '0;
                    end
                end
                ST_TERMS: begin
                    r_prev_high  <= r_high;
                    r_prev_low   <= r_low;
                    r_prev_close <= r_close;
                    if (r_bars != COUNT_MAX) r_bars <= r_bars + 1'b1;
                end
                ST_SUB, ST_ACC: begin
                    case (r_sel)
                        SEL_RANGE: r_range_sum <= (r_state == ST_SUB) ? sub_sum : acc_sat;
                        SEL_UP:    r_up_sum    <= (r_state == ST_SUB) ? sub_sum : acc_sat;
                        default:   r_down_sum  <= (r_state == ST_SUB) ? sub_sum : acc_sat;
                    endcase
                end
                default: begin
                    r_bars <= r_bars;
                end
            endcase
        end
    end

    // working registers of one bar
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (s_xfer) begin
                    r_high  <= i_s_tdata[31:0];
                    r_low   <= i_s_tdata[63:32];
                    r_close <= i_s_tdata[95:64];
                end
            end
            ST_TERMS: begin
                r_range_term <= {true_range, {FRAC_BITS{1'b0}}};
                r_up_term    <= {plus_dm, {FRAC_BITS{1'b0}}};
                r_down_term  <= {minus_dm, {FRAC_BITS{1'b0}}};
                r_warm       <= warm_bar;
                r_emit       <= emit_bar;
                r_sel        <= SEL_RANGE;
            end
            ST_ACC: begin
                r_sel <= (r_sel == SEL_DOWN) ? SEL_RANGE : r_sel + 1'b1;
            end
            ST_DI_PREP: begin
                if (di_zero || di_full) begin
                    if (r_sel[0]) r_minus <= di_quick;
                    else r_plus <= di_quick;
                    r_sel <= 2'd1;
                end
            end
            ST_DI_WAIT: begin
                if (div_done) begin
                    if (r_sel[0]) r_minus <= div_quot[DI_BITS-1:0];
                    else r_plus <= div_quot[DI_BITS-1:0];
                    r_sel <= 2'd1;
                end
            end
            default: begin
                r_sel <= r_sel;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_out_plus  <= r_plus;
            r_out_minus <= r_minus;
        end
    end

endmodule

`default_nettype wire

// ----- bench/tb_directional_indicator.sv -----
module tb_directional_indicator;

    import di_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        logic [31:0] high;
        logic [31:0] low;
        logic [31:0] close;
        logic        start;
    } t_bar;

    typedef struct packed {
        logic [DI_BITS-1:0] plus;
        logic [DI_BITS-1:0] minus;
    } t_di_pair;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [95:0]            i_s_tdata = '0;   // bar_high, bar_low, bar_close
    logic [0:0]             i_s_tuser = '0;   // series_start
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [47:0]            o_m_tdata;        // plus_di, down_di, zero pad
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [PERIOD_BITS-1:0] i_cfg_data = '0;

    directional_indicator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state, mirrors the block after reset
    logic [PERIOD_BITS-1:0] period_reg = PERIOD_RST;
    logic [31:0]            last_high = '0;
    logic [31:0]            last_low = '0;
    logic [31:0]            last_close = '0;
    logic [PERIOD_BITS-1:0] bar_count = '0;
    logic [63:0]            range_acc = '0;
    logic [63:0]            plus_acc = '0;
    logic [63:0]            minus_acc = '0;

    t_di_pair di_expected[$];
    t_bar     pending_bars[$];

    // stimulus generator state
    longint walk_level = 64'd1_000_000;
    longint walk_span = 64'd256;
    t_bar   last_gen = '0;

    t_bar     cur_bar = '0;
    t_bar     bar_in;
    t_di_pair seen_pair;
    t_di_pair want_pair;
    bit       bar_active = 1'b0;
    bit       bar_taken = 1'b0;
    bit       result_taken = 1'b0;
    int       send_gap = 0;
    int       send_calm = 0;
    int       take_hold = 0;
    int       take_calm = 0;
    int       cycle_count = 0;
    int       mismatches = 0;
    int       bars_sent = 0;
    int       results_seen = 0;
    int       cfg_writes = 0;

    function automatic logic [63:0] price_gap(input logic [63:0] a, input logic [63:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic logic [63:0] frac_term(input logic [63:0] d);
        if (d > (64'(SUM_MAX) >> FRAC_BITS))
            return 64'(SUM_MAX);
        return d << FRAC_BITS;
    endfunction

    function automatic logic [63:0] sum_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > 65'(SUM_MAX))
            return 64'(SUM_MAX);
        return s[63:0];
    endfunction

    // percent with 16 fraction bits, clipped at full scale
    function automatic logic [DI_BITS-1:0] di_ratio(input logic [63:0] num,
                                                    input logic [63:0] den);
        logic [127:0] q;
        if (num == 0 || den == 0)
            return '0;
        if (num >= den)
            return DI_SCALE;
        q = (128'(DI_SCALE) * 128'(num)) / 128'(den);
        if (q > 128'(DI_SCALE))
            q = 128'(DI_SCALE);
        return q[DI_BITS-1:0];
    endfunction

    task automatic advance_bar(input t_bar b);
        logic [63:0]            h, l, c, per, tr, up, dn, dp, dm;
        logic [PERIOD_BITS-1:0] idx;
        t_di_pair               pair;
        h = 64'(b.high);
        l = 64'(b.low);
        c = 64'(b.close);
        per = 64'(period_reg);
        if (per == 0)
            per = 1;
        if (per > MAX_PERIOD)
            per = MAX_PERIOD;
        if (b.start) begin
            bar_count = '0;
            range_acc = '0;
            plus_acc = '0;
            minus_acc = '0;
        end
        idx = bar_count;
        if (idx > 0) begin
            tr = price_gap(h, l);
            if (price_gap(h, 64'(last_close)) > tr)
                tr = price_gap(h, 64'(last_close));
            if (price_gap(l, 64'(last_close)) > tr)
                tr = price_gap(l, 64'(last_close));
            up = (h > 64'(last_high)) ? h - 64'(last_high) : 64'd0;
            dn = (64'(last_low) > l) ? 64'(last_low) - l : 64'd0;
            dp = 0;
            dm = 0;
            // equal moves cancel out
            if (up > dn)
                dp = up;
            else if (dn > up)
                dm = dn;
            if (64'(idx) < per) begin
                range_acc = sum_sat(range_acc, frac_term(tr));
                plus_acc = sum_sat(plus_acc, frac_term(dp));
                minus_acc = sum_sat(minus_acc, frac_term(dm));
            end else begin
                range_acc = sum_sat(range_acc - range_acc / per, frac_term(tr));
                plus_acc = sum_sat(plus_acc - plus_acc / per, frac_term(dp));
                minus_acc = sum_sat(minus_acc - minus_acc / per, frac_term(dm));
            end
        end
        if (64'(idx) >= per - 1) begin
            pair.plus = di_ratio(plus_acc, range_acc);
            pair.minus = di_ratio(minus_acc, range_acc);
            di_expected.push_back(pair);
        end
        last_high = b.high;
        last_low = b.low;
        last_close = b.close;
        bar_count = (idx < COUNT_MAX) ? idx + 1'b1 : COUNT_MAX;
    endtask

    task automatic draw_hold(inout int calm, output int hold);
        if (calm > 0) begin
            calm--;
            hold = 0;
        end else if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(8, 40);
            hold = 0;
        end else begin
            hold = $urandom_range(0, 9);
        end
    endtask

    function automatic logic [31:0] clamp_price(input longint v);
        if (v < 0)
            return 32'd0;
        if (v > 64'sd4294967295)
            return 32'hFFFF_FFFF;
        return v[31:0];
    endfunction

    task automatic queue_bar(input logic [31:0] h, input logic [31:0] l,
                             input logic [31:0] c, input bit s);
        t_bar b;
        b.high = h;
        b.low = l;
        b.close = c;
        b.start = s;
        pending_bars.push_back(b);
        last_gen = b;
    endtask

    // mostly price walks with random span, some noise, tied moves and repeated bars
    task automatic make_bars(input int count, input bit first_start, input int start_pct);
        int          pick;
        bit          mark;
        longint      hi, lo, d;
        logic [31:0] h, l;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            mark = (n == 0 && first_start) || pick < start_pct;
            if (mark) begin
                walk_level = longint'($urandom);
                walk_span = 64'd1 << $urandom_range(0, 28);
            end
            if (pick >= 90) begin
                queue_bar($urandom, $urandom, $urandom, mark);
            end else if (pick >= 84) begin
                d = longint'($urandom_range(0, 32'(walk_span)));
                h = clamp_price(longint'(last_gen.high) + d);
                l = clamp_price(longint'(last_gen.low) - d);
                queue_bar(h, l, $urandom, mark);
            end else if (pick >= 81) begin
                queue_bar(last_gen.high, last_gen.low, last_gen.close, mark);
            end else begin
                walk_level = walk_level + longint'($urandom_range(0, 32'(walk_span)))
                             - walk_span / 2;
                walk_level = longint'(clamp_price(walk_level));
                hi = longint'(clamp_price(walk_level
                              + longint'($urandom_range(0, 32'(walk_span)))));
                lo = longint'(clamp_price(walk_level
                              - longint'($urandom_range(0, 32'(walk_span)))));
                queue_bar(hi[31:0], lo[31:0],
                          lo[31:0] + $urandom_range(0, 32'(hi - lo)), mark);
            end
        end
    endtask

    task automatic set_period(input logic [PERIOD_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        period_reg = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // sender holds off until the block has drained, then lets a bar without result finish
    task automatic settle();
        while (pending_bars.size() != 0 || bar_active || di_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // bar driver
    always @(negedge i_clk) begin
        if (bar_taken) begin
            bar_active = 1'b0;
            bar_taken = 1'b0;
        end
        if (i_rst_n && !bar_active) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_bars.size() > 0) begin
                cur_bar = pending_bars.pop_front();
                bar_active = 1'b1;
                draw_hold(send_calm, send_gap);
            end
        end
        i_s_tvalid <= bar_active;
        i_s_tdata <= {cur_bar.close, cur_bar.low, cur_bar.high};
        i_s_tuser <= cur_bar.start;
    end

    // result receiver stalls
    always @(negedge i_clk) begin
        if (result_taken) begin
            result_taken = 1'b0;
            draw_hold(take_calm, take_hold);
        end
        if (take_hold == 0) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= 1'b0;
            if (o_m_tvalid)
                take_hold--;
        end
    end

    // monitor: result check first, then prediction for a bar taken at this edge
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end else if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                seen_pair.plus = o_m_tdata[DI_BITS-1:0];
                seen_pair.minus = o_m_tdata[2*DI_BITS-1:DI_BITS];
                result_taken = 1'b1;
                results_seen++;
                if (di_expected.size() == 0) begin
                    $display("%0t: result transfer with none expected, actual plus %0d minus %0d",
                             $time, seen_pair.plus, seen_pair.minus);
                    mismatches++;
                end else begin
                    want_pair = di_expected.pop_front();
                    if (seen_pair.plus !== want_pair.plus) begin
                        $display("%0t: plus_di expected %0d, actual %0d",
                                 $time, want_pair.plus, seen_pair.plus);
                        mismatches++;
                    end
                    if (seen_pair.minus !== want_pair.minus) begin
                        $display("%0t: down_di expected %0d, actual %0d",
                                 $time, want_pair.minus, seen_pair.minus);
                        mismatches++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                bar_in.high = i_s_tdata[31:0];
                bar_in.low = i_s_tdata[63:32];
                bar_in.close = i_s_tdata[95:64];
                bar_in.start = i_s_tuser[0];
                advance_bar(bar_in);
                bar_taken = 1'b1;
                bars_sent++;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_period(11'd2);
        // first bar after reset carries no mark
        queue_bar(32'd100, 32'd50, 32'd75, 1'b0);
        queue_bar(32'd120, 32'd60, 32'd110, 1'b0);
        queue_bar(32'd120, 32'd40, 32'd50, 1'b0);
        queue_bar(32'd130, 32'd30, 32'd80, 1'b0);   // equal up and down moves
        queue_bar(32'd130, 32'd30, 32'd80, 1'b0);   // no movement
        queue_bar(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0);
        queue_bar(32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0);   // low above high
        queue_bar(32'd0, 32'd0, 32'd0, 1'b1);
        queue_bar(32'd0, 32'd0, 32'd0, 1'b0);            // zero range
        queue_bar(32'd0, 32'd0, 32'd0, 1'b0);
        queue_bar(32'd5, 32'd5, 32'd5, 1'b0);
        // close far above high, so plus movement outgrows the range
        queue_bar(32'd10, 32'd0, 32'd1000, 1'b1);
        queue_bar(32'd1000, 32'd1000, 32'd1000, 1'b0);
        queue_bar(32'd2000, 32'd2000, 32'd2000, 1'b0);
        queue_bar(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 1'b0);
        queue_bar(32'd1, 32'd0, 32'd0, 1'b1);
        queue_bar(32'd0, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0);
        queue_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF, 1'b0);
        queue_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000, 1'b0);
        queue_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        queue_bar(32'd0, 32'd0, 32'd0, 1'b0);
        settle();

        set_period(11'd1);
        make_bars(150, 1'b1, 4);
        settle();
        // zero behaves as one; series carries on across the change
        set_period(11'd0);
        make_bars(60, 1'b0, 4);
        settle();
        set_period(11'd14);
        make_bars(250, 1'b0, 3);
        settle();
        set_period(11'd5);
        make_bars(240, 1'b1, 3);
        settle();
        set_period(PERIOD_MAX);
        make_bars(20, 1'b1, 0);
        settle();
        // above the maximum acts as the maximum; one long series reaches smoothing
        set_period(11'd2047);
        make_bars(1010, 1'b0, 0);
        settle();

        $display("covered %0d bars and %0d di results over %0d period writes",
                 bars_sent, results_seen, cfg_writes);
        $display("periods 0, 1, 2, 5, 14, max and above max, warm-up and smoothing");
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
src/di_pkg.sv
src/di_divider.sv
src/directional_indicator.sv
bench/tb_directional_indicator.sv
